FILE: design/timed_awning_motor_controller_unit_assert.svh
// Assertion macros shared by the RTL files.
`ifndef TIMED_AWNING_MOTOR_CONTROLLER_UNIT_ASSERT_SVH
`define TIMED_AWNING_MOTOR_CONTROLLER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define TAM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TAM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TAM_ASSERT(label, clk, rst_n, prop, msg)
`define TAM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: design/tam_pkg.sv
package tam_pkg;

    localparam int TIME_W   = 32;
    localparam int TRAVEL_W = 24;
    localparam int MODE_W   = 3;

    localparam logic [TRAVEL_W-1:0] TRAVEL_RESET = 24'd30000;
    localparam logic [TIME_W-1:0]   MUTE_TICKS   = 32'd400;

    localparam logic [MODE_W-1:0] MODE_UNKNOWN    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_EXTENDED   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RETRACTING = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RETRACTED  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_EXTENDING  = 3'd4;

    typedef struct packed {
        logic retract_button;
        logic extend_button;
        logic rain_lock;
    } tam_in_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              motor_pin;
        logic              direction_pin;
    } tam_out_t;

    // Control from the handshake stage to the tick logic
    typedef struct packed {
        logic advance;
        logic cfg_write;
    } tam_step_t;

endpackage

FILE: design/tam_tick.sv
`include "timed_awning_motor_controller_unit_assert.svh"

module tam_tick
    import tam_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  tam_step_t           step,
    input  logic [TRAVEL_W-1:0] cfg_data,
    input  tam_in_t             item,
    output tam_out_t            result
);

    logic [TRAVEL_W-1:0] travel_ms_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   mute_until_reg;
    logic [TIME_W-1:0]   deadline_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic                motor_reg;
    logic                direction_reg;

    logic [TIME_W-1:0]   now_next;
    logic [TIME_W-1:0]   mute_until_next;
    logic [TIME_W-1:0]   deadline_next;
    logic [MODE_W-1:0]   mode_next;
    logic                motor_next;
    logic                direction_next;

    logic                muted;
    logic                retract;
    logic                check_deadline;
    logic [TIME_W-1:0]   move_deadline;
    logic [TIME_W-1:0]   mute_deadline;

    assign muted         = mute_until_reg > now_reg;
    assign retract       = item.retract_button | item.rain_lock;
    assign move_deadline = now_reg + {{(TIME_W-TRAVEL_W){1'b0}}, travel_ms_reg};
    assign mute_deadline = now_reg + MUTE_TICKS;
    assign now_next      = now_reg + {{(TIME_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        mute_until_next = mute_until_reg;
        deadline_next   = deadline_reg;
        mode_next       = mode_reg;
        motor_next      = motor_reg;
        direction_next  = direction_reg;
        check_deadline  = 1'b0;
        if (!muted)
        begin
            check_deadline = 1'b1;
            if (retract)
            begin
                priority if (mode_reg == MODE_RETRACTED || mode_reg == MODE_RETRACTING)
                begin
                    check_deadline = 1'b0;
                end
                else if (mode_reg == MODE_EXTENDING)
                begin
                    // reverse request: stop and hold off input
                    check_deadline  = 1'b0;
                    mute_until_next = mute_deadline;
                    deadline_next   = '0;
                    motor_next      = 1'b1;
                    direction_next  = 1'b1;
                    mode_next       = MODE_UNKNOWN;
                end
                else
                begin
                    mode_next      = MODE_RETRACTING;
                    direction_next = 1'b1;
                    motor_next     = 1'b0;
                    deadline_next  = move_deadline;
                end
            end
            else if (item.extend_button)
            begin
                priority if (mode_reg == MODE_EXTENDED || mode_reg == MODE_EXTENDING)
                begin
                    check_deadline = 1'b0;
                end
                else if (mode_reg == MODE_RETRACTING)
                begin
                    check_deadline  = 1'b0;
                    mute_until_next = mute_deadline;
                    deadline_next   = '0;
                    motor_next      = 1'b1;
                    direction_next  = 1'b1;
                    mode_next       = MODE_UNKNOWN;
                end
                else
                begin
                    mode_next      = MODE_EXTENDING;
                    direction_next = 1'b0;
                    motor_next     = 1'b0;
                    deadline_next  = move_deadline;
                end
            end
        end
        // end of travel, also for a move started in this tick
        if (check_deadline && deadline_next != '0 && deadline_next <= now_reg)
        begin
            priority if (mode_next == MODE_RETRACTING)
            begin
                deadline_next  = '0;
                motor_next     = 1'b1;
                direction_next = 1'b1;
                mode_next      = MODE_RETRACTED;
            end
            else if (mode_next == MODE_EXTENDING)
            begin
                deadline_next  = '0;
                motor_next     = 1'b1;
                direction_next = 1'b1;
                mode_next      = MODE_EXTENDED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            travel_ms_reg  <= TRAVEL_RESET;
            now_reg        <= '0;
            mute_until_reg <= '0;
            deadline_reg   <= '0;
            mode_reg       <= MODE_UNKNOWN;
            motor_reg      <= 1'b1;
            direction_reg  <= 1'b1;
        end
        else
        begin
            if (step.cfg_write)
            begin
                travel_ms_reg <= cfg_data;
            end
            if (step.advance)
            begin
                now_reg        <= now_next;
                mute_until_reg <= mute_until_next;
                deadline_reg   <= deadline_next;
                mode_reg       <= mode_next;
                motor_reg      <= motor_next;
                direction_reg  <= direction_next;
            end
        end
    end

    assign result.mode          = mode_next;
    assign result.motor_pin     = motor_next;
    assign result.direction_pin = direction_next;

    `TAM_ASSERT(a_motor_runs_only_in_move, clk, rst_n, !motor_reg |-> (mode_reg == MODE_RETRACTING || mode_reg == MODE_EXTENDING), "motor running outside a move")
    `TAM_ASSERT(a_dir_low_only_extending, clk, rst_n, !direction_reg |-> (mode_reg == MODE_EXTENDING), "direction low while not extending")
    `TAM_ASSERT(a_time_holds_without_step, clk, rst_n, !step.advance |=> $stable(now_reg), "time advanced without a tick")

endmodule

FILE: design/timed_awning_motor_controller_unit.sv
// A word accepted into the input register passes through the tick logic into the
// result register, which drives out_item; an output stall can hold it in place.
// Throughput: one word per cycle while the output does not stall; the input register
// and the result register each hold one word, so input stalls only when both are full and the output stalls.
// Reset (rst_n, asynchronous, active low): pipeline empty, time and deadlines zero,
// mode unknown, both relays high, travel time 30000 ticks.
`include "timed_awning_motor_controller_unit_assert.svh"

module timed_awning_motor_controller_unit
    import tam_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tam_in_t             in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output tam_out_t            out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [TRAVEL_W-1:0] cfg_data
);

    logic      in_valid_reg;
    logic      in_valid_next;
    tam_in_t   in_item_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    tam_out_t  out_item_reg;
    tam_out_t  tick_result;
    tam_step_t step;
    logic      in_take;

    assign step.advance   = in_valid_reg & (~out_valid_reg | ~out_stall);
    assign step.cfg_write = cfg_valid & cfg_ready;
    assign in_stall       = in_valid_reg & ~step.advance;
    assign in_take        = in_valid & ~in_stall;
    assign cfg_ready      = ~in_valid_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step.advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg & out_stall;
        if (step.advance)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payloads while stalled
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item;
        end
        if (step.advance)
        begin
            out_item_reg <= tick_result;
        end
    end

    tam_tick u_tick (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .cfg_data (cfg_data),
        .item     (in_item_reg),
        .result   (tick_result)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `TAM_ASSERT(a_stall_only_when_full, clk, rst_n,
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall),
        "input stalled with room left")
    `TAM_ASSERT_ALWAYS(a_no_step_empty, clk, step.advance |-> in_valid_reg,
        "tick advanced with no word held")

endmodule

FILE: tb/tb.sv
module tb;
    import tam_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_500_000;

    // Button words: {retract_button, extend_button, rain_lock}
    localparam tam_in_t W_IDLE    = 3'b000;
    localparam tam_in_t W_RETRACT = 3'b100;
    localparam tam_in_t W_EXTEND  = 3'b010;
    localparam tam_in_t W_RAIN    = 3'b001;

    localparam tam_out_t RUN_RETRACT    = {MODE_RETRACTING, 1'b0, 1'b1};
    localparam tam_out_t RUN_EXTEND     = {MODE_EXTENDING, 1'b0, 1'b0};
    localparam tam_out_t HALT_UNKNOWN   = {MODE_UNKNOWN, 1'b1, 1'b1};
    localparam tam_out_t HALT_EXTENDED  = {MODE_EXTENDED, 1'b1, 1'b1};
    localparam tam_out_t HALT_RETRACTED = {MODE_RETRACTED, 1'b1, 1'b1};

    typedef struct {
        bit                  set_travel;
        logic [TRAVEL_W-1:0] travel;
        tam_in_t             word;
        int                  reps;
        bit                  typed;
        tam_out_t            want;
    } drill_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    tam_in_t             in_item = W_IDLE;
    logic                out_valid;
    logic                out_stall = 1'b0;
    tam_out_t            out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [TRAVEL_W-1:0] cfg_data = '0;

    // Awning model state
    logic [TRAVEL_W-1:0] travel_cfg = TRAVEL_RESET;
    logic [TIME_W-1:0]   clock_ms = '0;
    logic [TIME_W-1:0]   quiet_until = '0;
    logic [TIME_W-1:0]   end_ms = '0;
    logic [MODE_W-1:0]   cur_mode = MODE_UNKNOWN;
    logic                motor_lvl = 1'b1;
    logic                dir_lvl = 1'b1;
    bit                  tick_muted;

    tam_out_t            expected_relays[$];
    drill_row_t          drill[$];
    bit                  typed_en = 1'b0;
    tam_out_t            typed_want = '0;
    bit                  calm = 1'b0;
    int                  mismatches = 0;
    int                  ticks_sent = 0;
    int                  words_seen = 0;
    int                  cycle_count = 0;

    timed_awning_motor_controller_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void stop_motor(logic [MODE_W-1:0] next_mode);
        end_ms    = '0;
        motor_lvl = 1'b1;
        dir_lvl   = 1'b1;
        cur_mode  = next_mode;
    endfunction

    function automatic void start_move(logic [MODE_W-1:0] moving, logic [TIME_W-1:0] t);
        cur_mode  = moving;
        dir_lvl   = (moving == MODE_EXTENDING) ? 1'b0 : 1'b1;
        motor_lvl = 1'b0;
        end_ms    = t + TIME_W'(travel_cfg);
    endfunction

    // Advance the awning by one tick and return the relay word it shows
    function automatic tam_out_t awning_tick(tam_in_t w);
        logic              pull_in;
        logic              push_out;
        logic              done;
        logic [TIME_W-1:0] t;
        tam_out_t          r;
        t          = clock_ms;
        pull_in    = w.retract_button | w.rain_lock;
        push_out   = w.extend_button;
        tick_muted = (quiet_until > t);
        done       = tick_muted;
        if (!done && pull_in)
        begin
            if (cur_mode == MODE_RETRACTED || cur_mode == MODE_RETRACTING)
                done = 1'b1;
            else if (cur_mode == MODE_EXTENDING)
            begin
                quiet_until = t + MUTE_TICKS;
                stop_motor(MODE_UNKNOWN);
                done = 1'b1;
            end
            else
                start_move(MODE_RETRACTING, t);
        end
        else if (!done && push_out)
        begin
            if (cur_mode == MODE_EXTENDED || cur_mode == MODE_EXTENDING)
                done = 1'b1;
            else if (cur_mode == MODE_RETRACTING)
            begin
                quiet_until = t + MUTE_TICKS;
                stop_motor(MODE_UNKNOWN);
                done = 1'b1;
            end
            else
                start_move(MODE_EXTENDING, t);
        end
        // a button held in its own direction skips the deadline check
        if (!done && end_ms != '0 && end_ms <= t)
        begin
            if (cur_mode == MODE_RETRACTING)
                stop_motor(MODE_RETRACTED);
            else if (cur_mode == MODE_EXTENDING)
                stop_motor(MODE_EXTENDED);
        end
        clock_ms = t + 1;
        r.mode          = cur_mode;
        r.motor_pin     = motor_lvl;
        r.direction_pin = dir_lvl;
        return r;
    endfunction

    function automatic drill_row_t step_row(bit set_travel, logic [TRAVEL_W-1:0] travel,
                                            tam_in_t word, int reps, bit typed,
                                            tam_out_t want);
        drill_row_t row;
        row.set_travel = set_travel;
        row.travel     = travel;
        row.word       = word;
        row.reps       = reps;
        row.typed      = typed;
        row.want       = want;
        return row;
    endfunction

    always @(posedge clk)
    begin : scoreboard
        tam_out_t want;
        tam_out_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                travel_cfg = cfg_data;
            if (in_valid && !in_stall)
            begin
                want = awning_tick(in_item);
                ticks_sent++;
                if (typed_en)
                    want = typed_want;
                expected_relays.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                words_seen++;
                got = out_item;
                if (expected_relays.size() == 0)
                begin
                    $display("%0t: unexpected word, got mode %0d motor %0b dir %0b",
                             $time, got.mode, got.motor_pin, got.direction_pin);
                    mismatches++;
                end
                else
                begin
                    want = expected_relays.pop_front();
                    if (got.mode !== want.mode)
                    begin
                        $display("%0t: mode expected %0d, got %0d",
                                 $time, want.mode, got.mode);
                        mismatches++;
                    end
                    if (got.motor_pin !== want.motor_pin)
                    begin
                        $display("%0t: motor_pin expected %0b, got %0b",
                                 $time, want.motor_pin, got.motor_pin);
                        mismatches++;
                    end
                    if (got.direction_pin !== want.direction_pin)
                    begin
                        $display("%0t: direction_pin expected %0b, got %0b",
                                 $time, want.direction_pin, got.direction_pin);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Offer one word after a random gap; returns at the falling edge after acceptance
    task automatic offer(tam_in_t w, bit typed, tam_out_t want);
        int r;
        int gap;
        gap = 0;
        if (!calm)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                gap = $urandom_range(8, 40);
            else if (r < 30)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        in_item    <= w;
        typed_en   = typed;
        typed_want = want;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Drain the pipeline, then load a new travel time
    task automatic write_travel(logic [TRAVEL_W-1:0] v);
        in_valid <= 1'b0;
        while (expected_relays.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : receiver
        int  r;
        int  n;
        bit  squeezed;
        bit  level;
        squeezed = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!squeezed && words_seen >= 700)
            begin
                // long hold-off so the block fills and stalls its input
                squeezed = 1'b1;
                level    = 1'b1;
                n        = 150;
            end
            else if (calm)
            begin
                level = 1'b0;
                n     = 1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    level = 1'b0;
                    n     = $urandom_range(1, 8);
                end
                else if (r < 92)
                begin
                    level = 1'b1;
                    n     = $urandom_range(1, 3);
                end
                else
                begin
                    level = 1'b1;
                    n     = $urandom_range(10, 40);
                end
            end
            out_stall <= level;
            repeat (n) @(negedge clk);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        logic [TRAVEL_W-1:0] plan_travel [8];
        int                  plan_ticks [8];
        int                  r;
        int                  span;
        int                  idle_len;
        int                  target;
        bit                  go_in;
        bit                  last_in;
        tam_in_t             w;
        logic [2:0]          rnd3;

        // A move started at tick zero with zero travel has no deadline
        drill.push_back(step_row(1, 24'd0, W_RETRACT, 1, 1, RUN_RETRACT));
        drill.push_back(step_row(0, 24'd0, W_IDLE, 3, 0, '0));
        drill.push_back(step_row(0, 24'd0, W_EXTEND, 1, 1, HALT_UNKNOWN));
        drill.push_back(step_row(0, 24'd0, W_RETRACT, 1, 0, '0));
        drill.push_back(step_row(0, 24'd0, W_IDLE, 398, 0, '0));
        // mute over: zero travel ends in the same tick
        drill.push_back(step_row(0, 24'd0, W_EXTEND, 1, 1, HALT_EXTENDED));
        drill.push_back(step_row(0, 24'd0, W_EXTEND, 1, 0, '0));
        drill.push_back(step_row(0, 24'd0, W_RAIN, 1, 1, HALT_RETRACTED));
        drill.push_back(step_row(0, 24'd0, W_RETRACT | W_EXTEND, 1, 0, '0));
        // held button keeps the move alive past its deadline
        drill.push_back(step_row(1, 24'd3, W_EXTEND, 1, 1, RUN_EXTEND));
        drill.push_back(step_row(0, 24'd0, W_EXTEND, 4, 0, '0));
        drill.push_back(step_row(0, 24'd0, W_IDLE, 1, 0, '0));
        drill.push_back(step_row(1, 24'hFFFFFF, W_RETRACT, 1, 1, RUN_RETRACT));
        drill.push_back(step_row(0, 24'd0, 3'b111, 1, 0, '0));
        drill.push_back(step_row(1, 24'd1, W_IDLE, 2, 0, '0));
        drill.push_back(step_row(0, 24'd0, W_EXTEND, 1, 1, HALT_UNKNOWN));
        drill.push_back(step_row(0, 24'd0, W_EXTEND | W_RAIN, 1, 0, '0));

        plan_travel = '{24'd0, 24'd1, 24'd7, 24'd25, 24'd90, 24'hFFFFFF, 24'd2, 24'd300};
        plan_ticks  = '{150, 150, 150, 150, 150, 100, 150, 100};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (drill[i])
        begin
            if (drill[i].set_travel)
                write_travel(drill[i].travel);
            repeat (drill[i].reps)
                offer(drill[i].word, drill[i].typed, drill[i].want);
        end

        last_in = 1'b1;
        foreach (plan_travel[p])
        begin
            write_travel(plan_travel[p]);
            calm   = (p == 3);
            target = ticks_sent + plan_ticks[p];
            span   = (plan_travel[p] > 250) ? 250 : int'(plan_travel[p]);
            while (ticks_sent < target)
            begin
                r = $urandom_range(0, 99);
                if (r < 12)
                begin
                    rnd3 = 3'($urandom_range(0, 7));
                    w    = rnd3;
                    offer(w, 0, '0);
                end
                else
                begin
                    go_in = ($urandom_range(0, 99) < 60) ? !last_in : last_in;
                    if (go_in)
                    begin
                        case ($urandom_range(0, 3))
                            0: w = W_RETRACT;
                            1: w = W_RAIN;
                            2: w = W_RETRACT | W_RAIN;
                            default: w = {1'b1, 1'b1, 1'($urandom_range(0, 1))};
                        endcase
                    end
                    else
                        w = W_EXTEND;
                    last_in = go_in;
                    repeat ($urandom_range(1, 3))
                        offer(w, 0, '0);
                    // mostly let the move finish, sometimes cut it short
                    if ($urandom_range(0, 99) < 85)
                        idle_len = span + $urandom_range(1, 3);
                    else
                        idle_len = $urandom_range(0, span);
                    repeat (idle_len)
                        offer(W_IDLE, 0, '0);
                end
            end
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        while (expected_relays.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/tam_pkg.sv
design/tam_tick.sv
design/timed_awning_motor_controller_unit.sv
tb/tb.sv
